/* hdl/tcpq_pkg.sv */
// ----------------------------------------------------------------------------
// tcpq_pkg
// Shared types and constants of the two-class priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package tcpq_pkg;

	localparam int Depth       = 8;
	localparam int SlotW       = $clog2(Depth);
	localparam int CountW      = $clog2(Depth + 1);
	localparam int EntryW      = 65;
	localparam logic [3:0] CapacityReset = 4'd5;

	localparam logic [2:0] OP_ADD_NORMAL = 3'd0;
	localparam logic [2:0] OP_ADD_CRIT   = 3'd1;
	localparam logic [2:0] OP_SERVE      = 3'd2;
	localparam logic [2:0] OP_REMOVE     = 3'd3;
	localparam logic [2:0] OP_LOOKUP     = 3'd4;

	localparam logic [2:0] ST_DONE      = 3'd0;
	localparam logic [2:0] ST_FULL      = 3'd1;
	localparam logic [2:0] ST_DUP       = 3'd2;
	localparam logic [2:0] ST_EMPTY     = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND = 3'd4;

	typedef struct packed {
		logic [2:0]         operation;
		logic signed [31:0] entry_id;
		logic [31:0]        record_handle;
	} tcpq_in_t;

	typedef struct packed {
		logic [2:0]         status;
		logic signed [31:0] found_id;
		logic [31:0]        found_handle;
		logic               found_critical;
		logic [3:0]         occupancy;
	} tcpq_out_t;

	// One stored entry: critical flag, handle, id.
	typedef struct packed {
		logic        crit;
		logic [31:0] handle;
		logic [31:0] id;
	} tcpq_entry_t;

endpackage

`default_nettype wire

/* hdl/two_class_priority_queue.sv */
// ----------------------------------------------------------------------------
// two_class_priority_queue
// Ordered queue of up to Depth entries, critical entries ahead of normal ones.
// ----------------------------------------------------------------------------
//  Channel  | Signals                     | Direction
//  ---------+-----------------------------+----------
//  command  | in_valid, in_stall, in_data | in
//  result   | out_valid, out_stall, out_data | out
//  config   | cfg_we, cfg_wdata           | in
//
//  Every command scans the occupied entries once, one entry a cycle, then
//  decides. Adds, serves and removes then shift entries through the RAM,
//  one read (S_MVRD) and one write (S_MVWR) per entry moved, before the
//  result is reported.
//  Reset clears the count and control; RAM contents are not cleared.
//  A held result stalls the next command until the result transfer is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module two_class_priority_queue
	import tcpq_pkg::*;
(
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_stall,
	input  wire tcpq_in_t    in_data,
	output logic             out_valid,
	input  wire              out_stall,
	output tcpq_out_t        out_data,
	input  wire              cfg_we,
	input  wire [3:0]        cfg_wdata
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_SCAN  = 6'b000010,
		S_DEC   = 6'b000100,
		S_MVRD  = 6'b001000,
		S_MVWR  = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t              state_q;
	tcpq_in_t            cmd_q;
	logic [3:0]          cap_q;
	logic [CountW-1:0]   count_q;
	logic [CountW-1:0]   idx_q;      // address being read in the scan
	logic [CountW-1:0]   chk_q;      // address whose data arrives this cycle
	logic                chk_v_q;
	logic                hit_q;
	logic [CountW-1:0]   hit_pos_q;
	logic [CountW-1:0]   crit_end_q; // first non-critical position
	logic                crit_seen_end_q;
	tcpq_entry_t         head_q;
	tcpq_entry_t         found_q;
	logic [CountW-1:0]   mv_q;       // position being written during a shift
	logic                ins_q;
	logic [CountW-1:0]   stop_q;
	tcpq_out_t           res_q;
	logic                res_pend_q;

	logic                ram_we;
	logic [SlotW-1:0]    ram_waddr, ram_raddr;
	tcpq_entry_t         ram_wdata, ram_rdata;

	tcpq_ram #(.Width(EntryW), .Entries(Depth)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	logic [CountW-1:0] limit;
	logic [CountW:0]   cap_ext;
	logic              is_add;

	assign cap_ext  = (CountW + 1)'(cap_q);
	assign limit    = (cap_ext > (CountW + 1)'(Depth)) ? CountW'(Depth)
		: CountW'(cap_ext);
	assign is_add   = (cmd_q.operation == OP_ADD_NORMAL) ||
		(cmd_q.operation == OP_ADD_CRIT);
	assign in_stall = (state_q != S_IDLE) || res_pend_q;
	assign out_valid = res_pend_q;
	assign out_data  = res_q;

	// RAM address and write selection.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = mv_q[SlotW-1:0];
		ram_wdata = ram_rdata;
		ram_raddr = idx_q[SlotW-1:0];
		if (state_q == S_MVRD) begin
			ram_raddr = ins_q ? SlotW'(mv_q - 1'b1) : SlotW'(mv_q + 1'b1);
		end
		if (state_q == S_MVWR) begin
			ram_we = 1'b1;
			if (ins_q && mv_q == stop_q) begin
				ram_wdata.id     = cmd_q.entry_id;
				ram_wdata.handle = cmd_q.record_handle;
				ram_wdata.crit   = (cmd_q.operation == OP_ADD_CRIT);
			end
		end
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CapacityReset;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// Command sequencer: scan, decide, shift, report.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			res_pend_q <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				res_pend_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid && !in_stall) begin
						cmd_q           <= in_data;
						idx_q           <= '0;
						chk_v_q         <= 1'b0;
						hit_q           <= 1'b0;
						crit_end_q      <= count_q;
						crit_seen_end_q <= 1'b0;
						state_q         <= S_SCAN;
					end
				end
				S_SCAN: begin
					// Data for chk_q arrives now; issue the next read.
					if (chk_v_q) begin
						if (chk_q == '0) begin
							head_q <= ram_rdata;
						end
						if (!hit_q && ram_rdata.id == cmd_q.entry_id) begin
							hit_q     <= 1'b1;
							hit_pos_q <= chk_q;
							found_q   <= ram_rdata;
						end
						if (!crit_seen_end_q && !ram_rdata.crit) begin
							crit_seen_end_q <= 1'b1;
							crit_end_q      <= chk_q;
						end
					end
					chk_q <= idx_q;
					if (idx_q < count_q) begin
						chk_v_q <= 1'b1;
						idx_q   <= idx_q + 1'b1;
					end else begin
						chk_v_q <= 1'b0;
						if (!chk_v_q) begin
							state_q <= S_DEC;
						end
					end
				end
				S_DEC: begin
					res_q.found_id       <= '0;
					res_q.found_handle   <= '0;
					res_q.found_critical <= 1'b0;
					res_q.status         <= ST_DONE;
					state_q              <= S_DONE;
					if (is_add) begin
						if (count_q >= limit) begin
							res_q.status <= ST_FULL;
						end else if (hit_q) begin
							res_q.status <= ST_DUP;
						end else begin
							ins_q  <= 1'b1;
							stop_q <= (cmd_q.operation == OP_ADD_CRIT) ? crit_end_q : count_q;
							mv_q   <= count_q;
							state_q <= S_MVRD;
						end
					end else if (cmd_q.operation == OP_SERVE ||
						cmd_q.operation == OP_REMOVE || cmd_q.operation == OP_LOOKUP) begin
						if (count_q == '0) begin
							res_q.status <= ST_EMPTY;
						end else if (cmd_q.operation == OP_SERVE) begin
							res_q.found_id       <= head_q.id;
							res_q.found_handle   <= head_q.handle;
							res_q.found_critical <= head_q.crit;
							ins_q   <= 1'b0;
							mv_q    <= '0;
							stop_q  <= count_q - 1'b1;
							state_q <= S_MVRD;
						end else if (!hit_q) begin
							res_q.status <= ST_NOT_FOUND;
						end else begin
							res_q.found_id       <= found_q.id;
							res_q.found_handle   <= found_q.handle;
							res_q.found_critical <= found_q.crit;
							if (cmd_q.operation == OP_REMOVE) begin
								ins_q   <= 1'b0;
								mv_q    <= hit_pos_q;
								stop_q  <= count_q - 1'b1;
								state_q <= S_MVRD;
							end
						end
					end
				end
				S_MVRD: begin
					// Removal with nothing behind it ends at once.
					if (!ins_q && mv_q == stop_q) begin
						count_q <= count_q - 1'b1;
						state_q <= S_DONE;
					end else begin
						state_q <= S_MVWR;
					end
				end
				S_MVWR: begin
					if (ins_q) begin
						if (mv_q == stop_q) begin
							count_q <= count_q + 1'b1;
							state_q <= S_DONE;
						end else begin
							mv_q    <= mv_q - 1'b1;
							state_q <= S_MVRD;
						end
					end else begin
						mv_q    <= mv_q + 1'b1;
						state_q <= S_MVRD;
					end
				end
				S_DONE: begin
					res_q.occupancy <= 4'(count_q);
					res_pend_q      <= 1'b1;
					state_q         <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* hdl/tcpq_ram.sv */
// ----------------------------------------------------------------------------
// tcpq_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tcpq_ram #(
	parameter int Width = 8,
	parameter int Entries = 8
) (
	input  wire                        clk,
	input  wire                        we,
	input  wire [$clog2(Entries)-1:0]  waddr,
	input  wire [Width-1:0]            wdata,
	input  wire [$clog2(Entries)-1:0]  raddr,
	output logic [Width-1:0]           rdata
);

	logic [Width-1:0] mem_q [Entries];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire
